[sv/fpdt_pkg.sv]
// ----------------------------------------------------------------------------
// Frame pacing deadline timer package
// Widths, constants, result codes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package fpdt_pkg;

  localparam int unsigned RATE_W      = 10;
  localparam int unsigned SEC_W       = 32;
  localparam int unsigned USEC_W      = 20;
  localparam int unsigned WAIT_W      = 21;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 24;

  // The shared divider takes a numerator aligned to its top bit.
  localparam int unsigned DIV_NUM_W = 30;
  localparam int unsigned DIV_CNT_W = 5;

  // Signed wait and the product used for the overrun test.
  localparam int unsigned W_W     = 23;
  localparam int unsigned PRODW_W = 32;

  localparam logic [RATE_W-1:0]  RATE_RESET   = 10'd60;
  localparam logic [USEC_W-1:0]  USEC_PER_SEC = 20'd1000000;
  localparam logic [WAIT_W-1:0]  TWO_SEC_USEC = 21'd2000000;
  localparam logic [WAIT_W-1:0]  OVERRUN_NUM  = 21'd1500000;

  typedef enum logic [STATUS_W-1:0] {
    ST_ON_TIME  = 2'd0,
    ST_UNDERRUN = 2'd1,
    ST_OVERRUN  = 2'd2,
    ST_RESTART  = 2'd3
  } status_t;

  // Commands from the controller, one strobe per datapath step.
  typedef struct packed {
    logic capture;
    logic restart;
    logic fold_start;
    logic fold_load;
    logic f_direct;
    logic mul;
    logic dl_start;
    logic dl_load;
    logic norm;
    logic cmp;
    logic mulw;
    logic decide;
    logic per_start;
    logic per_load;
    logic per_fin;
    logic emit;
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic op;
    logic fold_need;
    logic div_done;
    logic overrun;
    logic out_free;
  } sts_t;

endpackage

[sv/fpdt_div.sv]
// ----------------------------------------------------------------------------
// Frame pacing shared divider
// Restoring divider, one quotient bit per cycle. The numerator arrives aligned
// to the top bit and the number of bits to process is given with it.
// ----------------------------------------------------------------------------
module fpdt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fpdt_pkg::DIV_NUM_W-1:0] num,
  input  logic [fpdt_pkg::DIV_CNT_W-1:0] iters,
  input  logic [fpdt_pkg::RATE_W-1:0]    den,
  output logic                           done,
  output logic [fpdt_pkg::DIV_NUM_W-1:0] quo,
  output logic [fpdt_pkg::RATE_W-1:0]    rem
);

  logic [fpdt_pkg::DIV_NUM_W-1:0] acc_r, acc_nxt;
  logic [fpdt_pkg::RATE_W-1:0]    rem_r, rem_nxt;
  logic [fpdt_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [fpdt_pkg::RATE_W:0]      trial;
  logic [fpdt_pkg::RATE_W:0]      diff;
  logic                           ge;

  assign trial = {rem_r, acc_r[fpdt_pkg::DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = num;
      rem_nxt = '0;
      cnt_nxt = iters;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // The partial remainder stays below the divisor, so its top bit drops.
      rem_nxt = ge ? diff[fpdt_pkg::RATE_W-1:0] : trial[fpdt_pkg::RATE_W-1:0];
      acc_nxt = {acc_r[fpdt_pkg::DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r - fpdt_pkg::DIV_CNT_W'(1);
      if (cnt_r == fpdt_pkg::DIV_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = acc_r;
  assign rem  = rem_r;

endmodule

[sv/fpdt_dp.sv]
// ----------------------------------------------------------------------------
// Frame pacing datapath
// Holds the rate register, frame count and anchor time, works out the deadline
// and the wait, and keeps the output register.
// ----------------------------------------------------------------------------
module fpdt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fpdt_pkg::RATE_W-1:0]      cfg_data,
  input  logic [fpdt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  fpdt_pkg::cmd_t                   cmd,
  output fpdt_pkg::sts_t                   sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fpdt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [fpdt_pkg::STATUS_W-1:0]    out_tuser
);

  localparam int unsigned RATE_W = fpdt_pkg::RATE_W;
  localparam int unsigned SEC_W  = fpdt_pkg::SEC_W;
  localparam int unsigned USEC_W = fpdt_pkg::USEC_W;
  localparam int unsigned WAIT_W = fpdt_pkg::WAIT_W;
  localparam int unsigned NUM_W  = fpdt_pkg::DIV_NUM_W;
  localparam int unsigned CNT_W  = fpdt_pkg::DIV_CNT_W;
  localparam int unsigned W_W    = fpdt_pkg::W_W;
  localparam int unsigned PW_W   = fpdt_pkg::PRODW_W;

  typedef struct packed {
    logic [1:0]        carry;
    logic [USEC_W-1:0] usec;
  } usec_norm_t;

  // Folds up to two whole seconds out of a microsecond count.
  function automatic usec_norm_t norm_usec(input logic [WAIT_W-1:0] u);
    usec_norm_t n;
    if (u >= fpdt_pkg::TWO_SEC_USEC) begin
      n.carry = 2'd2;
      n.usec  = USEC_W'(u - fpdt_pkg::TWO_SEC_USEC);
    end else if (u >= WAIT_W'(fpdt_pkg::USEC_PER_SEC)) begin
      n.carry = 2'd1;
      n.usec  = USEC_W'(u - WAIT_W'(fpdt_pkg::USEC_PER_SEC));
    end else begin
      n.carry = 2'd0;
      n.usec  = u[USEC_W-1:0];
    end
    return n;
  endfunction

  // Architectural state.
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [RATE_W-1:0] frame_index_r, frame_index_nxt;
  logic [SEC_W-1:0]  anchor_sec_r, anchor_sec_nxt;
  logic [USEC_W-1:0] anchor_usec_r, anchor_usec_nxt;

  // Working registers for one item.
  logic                  op_r, op_nxt;
  logic [SEC_W-1:0]      nsec_r, nsec_nxt;
  logic [USEC_W-1:0]     nusec_r, nusec_nxt;
  logic [RATE_W-1:0]     f_r, f_nxt;
  logic [NUM_W-1:0]      prod_r, prod_nxt;
  logic [WAIT_W-1:0]     du_raw_r, du_raw_nxt;
  logic [USEC_W-1:0]     du_r, du_nxt;
  logic [SEC_W-1:0]      sdiff_r, sdiff_nxt;
  logic signed [W_W-1:0] w_r, w_nxt;
  logic                  neg_r, neg_nxt;
  logic                  big_r, big_nxt;
  logic [PW_W-1:0]       prodw_r, prodw_nxt;
  logic [USEC_W-1:0]     per_r, per_nxt;
  logic [WAIT_W-1:0]     u_r, u_nxt;
  logic [WAIT_W-1:0]     res_wait_r, res_wait_nxt;
  fpdt_pkg::status_t     res_status_r, res_status_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [WAIT_W-1:0]     out_wait_r, out_wait_nxt;
  fpdt_pkg::status_t     out_status_r, out_status_nxt;

  logic [RATE_W-1:0] rate_eff;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [CNT_W-1:0]  div_iters;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [RATE_W-1:0] div_rem;
  usec_norm_t        dl_norm;
  usec_norm_t        per_norm;
  logic [WAIT_W-1:0] sd_base;
  logic              underrun;
  logic              overrun;

  assign rate_eff = (rate_r == '0) ? RATE_W'(1) : rate_r;

  // Operand selection for the shared divider.
  always_comb begin
    div_start = cmd.fold_start | cmd.dl_start | cmd.per_start;
    div_num   = prod_r;
    div_iters = CNT_W'(NUM_W);
    if (cmd.fold_start) begin
      div_num   = {frame_index_r, {(NUM_W-RATE_W){1'b0}}};
      div_iters = CNT_W'(RATE_W);
    end else if (cmd.per_start) begin
      div_num   = {fpdt_pkg::USEC_PER_SEC, {(NUM_W-USEC_W){1'b0}}};
      div_iters = CNT_W'(USEC_W);
    end
  end

  fpdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .iters (div_iters),
    .den   (rate_eff),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign dl_norm  = norm_usec(du_raw_r);
  assign per_norm = norm_usec(u_r);

  // Only a seconds difference of 0, 1 or 2 needs the exact wait; below that
  // the deadline has passed and above it the wait is far beyond any limit.
  always_comb begin
    case (sdiff_r[1:0])
      2'd1:    sd_base = WAIT_W'(fpdt_pkg::USEC_PER_SEC);
      2'd2:    sd_base = fpdt_pkg::TWO_SEC_USEC;
      default: sd_base = '0;
    endcase
  end

  // The sign of the short wait means nothing once the seconds difference is large.
  assign underrun = neg_r | (~big_r & w_r[W_W-1]);
  assign overrun  = ~underrun & (big_r | (prodw_r > PW_W'(fpdt_pkg::OVERRUN_NUM)));

  always_comb begin
    rate_nxt        = rate_r;
    frame_index_nxt = frame_index_r;
    anchor_sec_nxt  = anchor_sec_r;
    anchor_usec_nxt = anchor_usec_r;
    op_nxt          = op_r;
    nsec_nxt        = nsec_r;
    nusec_nxt       = nusec_r;
    f_nxt           = f_r;
    prod_nxt        = prod_r;
    du_raw_nxt      = du_raw_r;
    du_nxt          = du_r;
    sdiff_nxt       = sdiff_r;
    w_nxt           = w_r;
    neg_nxt         = neg_r;
    big_nxt         = big_r;
    prodw_nxt       = prodw_r;
    per_nxt         = per_r;
    u_nxt           = u_r;
    res_wait_nxt    = res_wait_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r & ~out_tready;
    out_wait_nxt    = out_wait_r;
    out_status_nxt  = out_status_r;

    if (cfg_we) begin
      rate_nxt = cfg_data;
    end

    if (cmd.capture) begin
      op_nxt    = in_tuser;
      nsec_nxt  = in_tdata[SEC_W-1:0];
      nusec_nxt = in_tdata[SEC_W+USEC_W-1:SEC_W];
    end

    if (cmd.restart) begin
      frame_index_nxt = '0;
      anchor_sec_nxt  = nsec_r;
      anchor_usec_nxt = nusec_r;
      res_wait_nxt    = '0;
      res_status_nxt  = fpdt_pkg::ST_RESTART;
    end

    // A count at or past the rate folds whole seconds into the anchor.
    if (cmd.f_direct) begin
      f_nxt = frame_index_r + RATE_W'(1);
    end
    if (cmd.fold_load) begin
      f_nxt          = div_rem + RATE_W'(1);
      anchor_sec_nxt = anchor_sec_r + SEC_W'(div_quo[RATE_W-1:0]);
    end

    if (cmd.mul) begin
      prod_nxt = NUM_W'(f_r) * NUM_W'(fpdt_pkg::USEC_PER_SEC);
    end

    if (cmd.dl_load) begin
      du_raw_nxt = WAIT_W'(div_quo[USEC_W-1:0]) + WAIT_W'(anchor_usec_r);
    end

    if (cmd.norm) begin
      du_nxt    = dl_norm.usec;
      sdiff_nxt = anchor_sec_r + SEC_W'(dl_norm.carry) - nsec_r;
    end

    if (cmd.cmp) begin
      neg_nxt = sdiff_r[SEC_W-1];
      big_nxt = ~sdiff_r[SEC_W-1] & ((|sdiff_r[SEC_W-2:2]) | (&sdiff_r[1:0]));
      w_nxt   = $signed({2'b00, sd_base}) + $signed({3'b000, du_r})
              - $signed({3'b000, nusec_r});
    end

    // The wait exceeds 1500000 / rate exactly when wait * rate exceeds 1500000.
    if (cmd.mulw) begin
      prodw_nxt = PW_W'(w_r[W_W-2:0]) * PW_W'(rate_eff);
    end

    if (cmd.decide) begin
      if (underrun) begin
        frame_index_nxt = '0;
        anchor_sec_nxt  = nsec_r;
        anchor_usec_nxt = nusec_r;
        res_wait_nxt    = '0;
        res_status_nxt  = fpdt_pkg::ST_UNDERRUN;
      end else begin
        frame_index_nxt = f_r;
        res_wait_nxt    = w_r[WAIT_W-1:0];
        res_status_nxt  = fpdt_pkg::ST_ON_TIME;
      end
    end

    if (cmd.per_load) begin
      per_nxt = div_quo[USEC_W-1:0];
      u_nxt   = WAIT_W'(nusec_r) + WAIT_W'(div_quo[USEC_W-1:0]);
    end

    if (cmd.per_fin) begin
      frame_index_nxt = '0;
      anchor_sec_nxt  = nsec_r + SEC_W'(per_norm.carry);
      anchor_usec_nxt = per_norm.usec;
      res_wait_nxt    = WAIT_W'(per_r);
      res_status_nxt  = fpdt_pkg::ST_OVERRUN;
    end

    if (cmd.emit) begin
      out_valid_nxt  = 1'b1;
      out_wait_nxt   = res_wait_r;
      out_status_nxt = res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r        <= fpdt_pkg::RATE_RESET;
      frame_index_r <= '0;
      anchor_sec_r  <= '0;
      anchor_usec_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      rate_r        <= rate_nxt;
      frame_index_r <= frame_index_nxt;
      anchor_sec_r  <= anchor_sec_nxt;
      anchor_usec_r <= anchor_usec_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    nsec_r       <= nsec_nxt;
    nusec_r      <= nusec_nxt;
    f_r          <= f_nxt;
    prod_r       <= prod_nxt;
    du_raw_r     <= du_raw_nxt;
    du_r         <= du_nxt;
    sdiff_r      <= sdiff_nxt;
    w_r          <= w_nxt;
    neg_r        <= neg_nxt;
    big_r        <= big_nxt;
    prodw_r      <= prodw_nxt;
    per_r        <= per_nxt;
    u_r          <= u_nxt;
    res_wait_r   <= res_wait_nxt;
    res_status_r <= res_status_nxt;
    out_wait_r   <= out_wait_nxt;
    out_status_r <= out_status_nxt;
  end

  assign sts.op        = op_r;
  assign sts.fold_need = frame_index_r >= rate_eff;
  assign sts.div_done  = div_done;
  assign sts.overrun   = overrun;
  assign sts.out_free  = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(fpdt_pkg::OUT_TDATA_W-WAIT_W){1'b0}}, out_wait_r};
  assign out_tuser  = out_status_r;

endmodule

[sv/fpdt_ctrl.sv]
// ----------------------------------------------------------------------------
// Frame pacing controller
// Steps the datapath through one word: frame fold, deadline division, wait
// comparison, overrun period and hand-over to the output register.
// ----------------------------------------------------------------------------
module fpdt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  fpdt_pkg::sts_t sts,
  output fpdt_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DECODE   = 13'b0000000000010,
    S_FOLD     = 13'b0000000000100,
    S_MUL      = 13'b0000000001000,
    S_DL_START = 13'b0000000010000,
    S_DL_WAIT  = 13'b0000000100000,
    S_NORM     = 13'b0000001000000,
    S_CMP      = 13'b0000010000000,
    S_MULW     = 13'b0000100000000,
    S_DECIDE   = 13'b0001000000000,
    S_PER_WAIT = 13'b0010000000000,
    S_PER_FIN  = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.op) begin
          cmd.restart = 1'b1;
          state_nxt   = S_DONE;
        end else if (sts.fold_need) begin
          cmd.fold_start = 1'b1;
          state_nxt      = S_FOLD;
        end else begin
          cmd.f_direct = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_FOLD: begin
        if (sts.div_done) begin
          cmd.fold_load = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DL_START;
      end
      S_DL_START: begin
        cmd.dl_start = 1'b1;
        state_nxt    = S_DL_WAIT;
      end
      S_DL_WAIT: begin
        if (sts.div_done) begin
          cmd.dl_load = 1'b1;
          state_nxt   = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_MULW;
      end
      S_MULW: begin
        cmd.mulw  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.overrun) begin
          cmd.per_start = 1'b1;
          state_nxt     = S_PER_WAIT;
        end else begin
          cmd.decide = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_PER_WAIT: begin
        if (sts.div_done) begin
          cmd.per_load = 1'b1;
          state_nxt    = S_PER_FIN;
        end
      end
      S_PER_FIN: begin
        cmd.per_fin = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // Wait for the output register to drain before handing over.
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/frame_pacing_deadline_timer_unit.sv]
// ----------------------------------------------------------------------------
// Frame pacing deadline timer
// Paces frames to a programmed rate: each input word carries the current time
// and a restart or next-frame request, each output word gives the wait until
// the next frame deadline and whether the stream was on time.
//
// The in_ channel takes one word at a time; in_tready is high only while the
// block is free. Every accepted word gives exactly one out_ word.
// A restart goes from decode straight to the hand-over state. A next frame
// runs the 30-step shared divider that forms frame*1000000/rate, with an
// extra division first when the frame count has to be folded back into one
// second, and another division on an overrun, where the divider forms the
// frame period.
// A new word is taken as soon as the previous result sits in the output
// register, so a stalled receiver holds only that one result; the block then
// finishes the next word and waits with it until the output register frees.
// cfg_data writes the frame rate, a rate of zero acting as one; cfg_ready is
// always high and writes belong in idle periods. Reset sets the rate to 60,
// clears the frame count and anchor time and empties the output register.
// ----------------------------------------------------------------------------
module frame_pacing_deadline_timer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fpdt_pkg::RATE_W-1:0]      cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // now_sec [31:0], now_usec [51:32], zero [55:52]
  input  logic [fpdt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op [0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // wait_usec [20:0], zero [23:21]
  output logic [fpdt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status [1:0]
  output logic [fpdt_pkg::STATUS_W-1:0]    out_tuser
);

  fpdt_pkg::cmd_t cmd;
  fpdt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  fpdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpdt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[dv/tb_frame_pacing_deadline_timer_unit.sv]
// ----------------------------------------------------------------------------
// Frame pacing deadline timer testbench
// Drives restart and next-frame words into the pacer, predicts the wait and
// status of each one from its own copy of the frame count, anchor time and
// frame rate, and compares every result word in order. A directed opening
// covers the boundaries; random phases follow at a range of rates.
// ----------------------------------------------------------------------------
module tb_frame_pacing_deadline_timer_unit;

  localparam logic OP_RESTART   = 1'b0;
  localparam logic OP_NEXT      = 1'b1;
  localparam int   STALL_LIMIT  = 4000;
  localparam int   DRAIN_CYCLES = 100;
  localparam int   IDLE_PCT     = 22;

  typedef struct packed {
    logic                        op;
    logic [fpdt_pkg::SEC_W-1:0]  now_sec;
    logic [fpdt_pkg::USEC_W-1:0] now_usec;
  } frame_req_t;

  typedef struct packed {
    logic [fpdt_pkg::WAIT_W-1:0] wait_usec;
    fpdt_pkg::status_t           status;
  } pace_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             cfg_valid  = 1'b0;
  logic [fpdt_pkg::RATE_W-1:0]      cfg_data   = '0;
  logic                             in_tvalid  = 1'b0;
  logic [fpdt_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             in_tuser   = 1'b0;
  logic                             out_tready = 1'b0;
  logic                             cfg_ready;
  logic                             in_tready;
  logic                             out_tvalid;
  logic [fpdt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [fpdt_pkg::STATUS_W-1:0]    out_tuser;

  frame_req_t req_q[$];
  pace_t      wait_q[$];
  int         words_open = 0;
  int         errors     = 0;
  int         stall_cnt  = 0;
  bit         quiet      = 1'b0;
  bit         in_taken   = 1'b0;

  // Predicted state of the pacer.
  logic [fpdt_pkg::RATE_W-1:0] pace_rate = fpdt_pkg::RATE_RESET;
  logic [9:0]                  frame_cnt = '0;
  logic [fpdt_pkg::SEC_W-1:0]  base_sec  = '0;
  logic [fpdt_pkg::USEC_W-1:0] base_usec = '0;

  // Stimulus side: the rate currently programmed and the running wall clock.
  logic [fpdt_pkg::RATE_W-1:0] stim_rate = fpdt_pkg::RATE_RESET;
  longint unsigned             t_us      = 0;

  frame_pacing_deadline_timer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pace_t pace_frame(input logic op,
                                       input logic [fpdt_pkg::SEC_W-1:0] nsec,
                                       input logic [fpdt_pkg::USEC_W-1:0] nusec);
    pace_t                      r;
    longint unsigned            rate, f, k, du, period, u;
    logic [fpdt_pkg::SEC_W-1:0] dsec, sdiff;
    longint                     w;
    rate = (pace_rate == 0) ? 1 : pace_rate;
    r.wait_usec = '0;
    if (op == OP_RESTART) begin
      frame_cnt = '0;
      base_sec  = nsec;
      base_usec = nusec;
      r.status  = fpdt_pkg::ST_RESTART;
    end else begin
      // Whole seconds of frames are folded into the anchor first.
      f = frame_cnt + 1;
      k = (f - 1) / rate;
      f = f - k * rate;
      base_sec  = base_sec + k[31:0];
      frame_cnt = f[9:0];
      du    = (64'd1000000 * f) / rate + base_usec;
      dsec  = base_sec + 32'(du / 1000000);
      du    = du % 1000000;
      sdiff = dsec - nsec;
      w = longint'($signed(sdiff)) * 1000000 + longint'(du) - longint'(nusec);
      if (w < 0) begin
        base_sec  = nsec;
        base_usec = nusec;
        frame_cnt = '0;
        r.status  = fpdt_pkg::ST_UNDERRUN;
      end else if (w > longint'(1500000 / rate)) begin
        period    = 1000000 / rate;
        u         = nusec + period;
        base_sec  = nsec + 32'(u / 1000000);
        base_usec = 20'(u % 1000000);
        frame_cnt = '0;
        r.wait_usec = 21'(period);
        r.status  = fpdt_pkg::ST_OVERRUN;
      end else begin
        r.wait_usec = 21'(w);
        r.status  = fpdt_pkg::ST_ON_TIME;
      end
    end
    return r;
  endfunction

  // Drive at the falling edge; a word stays put until it has been taken.
  always @(negedge clk) begin : drive
    frame_req_t nxt;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      if (!in_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (req_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, nxt.now_usec, nxt.now_sec};
          in_tuser  <= nxt.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : observe
    pace_t exp_w;
    bit    moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        pace_rate = cfg_data;
        moved = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        wait_q.push_back(pace_frame(in_tuser, in_tdata[31:0], in_tdata[51:32]));
        in_taken = 1'b1;
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (wait_q.size() == 0) begin
          $display("%0t: unexpected word, wait_usec %0d status %0d", $time,
                   out_tdata[fpdt_pkg::WAIT_W-1:0], out_tuser);
          errors++;
        end else begin
          exp_w = wait_q.pop_front();
          words_open--;
          if (out_tdata[fpdt_pkg::WAIT_W-1:0] != exp_w.wait_usec) begin
            $display("%0t: wait_usec expected %0d, actual %0d", $time, exp_w.wait_usec,
                     out_tdata[fpdt_pkg::WAIT_W-1:0]);
            errors++;
          end
          if (out_tuser != exp_w.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, exp_w.status,
                     out_tuser);
            errors++;
          end
        end
      end
    end
    stall_cnt = moved ? 0 : stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_req(input logic op, input logic [fpdt_pkg::SEC_W-1:0] sec,
                          input logic [fpdt_pkg::USEC_W-1:0] usec);
    frame_req_t r;
    r.op       = op;
    r.now_sec  = sec;
    r.now_usec = usec;
    req_q.push_back(r);
    words_open++;
  endtask

  // Sends the wall clock, now and then with the microseconds above a second.
  task automatic push_now(input logic op);
    logic [fpdt_pkg::SEC_W-1:0]  sec;
    logic [fpdt_pkg::USEC_W-1:0] usec;
    sec  = 32'(t_us / 1000000);
    usec = 20'(t_us % 1000000);
    if ($urandom_range(99) < 5 && usec < 20'd48576) begin
      sec  = sec - 1;
      usec = usec + fpdt_pkg::USEC_PER_SEC;
    end
    push_req(op, sec, usec);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (words_open != 0 || req_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_rate(input logic [fpdt_pkg::RATE_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    stim_rate = v;
  endtask

  // Mostly frames arriving about one period apart, with late and early words,
  // stray restarts and random words mixed in.
  task automatic stream(input int n, input bit restart_first);
    longint unsigned period, adv;
    int              rr;
    period = 1000000 / ((stim_rate == 0) ? 1 : stim_rate);
    if (restart_first) push_now(OP_RESTART);
    repeat (n) begin
      rr = $urandom_range(99);
      if (rr < 3) begin
        push_now(OP_RESTART);
      end else if (rr < 6) begin
        push_req(1'($urandom_range(1)), $urandom, 20'($urandom));
      end else begin
        rr = $urandom_range(99);
        if (rr < 78)
          adv = period - period / 8 + 64'($urandom_range(32'(period / 4)));
        else if (rr < 88)
          adv = 64'($urandom_range(32'(2 * period)));
        else if (rr < 94)
          adv = 64'($urandom_range(32'(period / 3)));
        else
          adv = 64'($urandom_range(32'(3 * period + 2000000)));
        t_us += adv;
        push_now(OP_NEXT);
      end
    end
  endtask

  task automatic phase(input logic [fpdt_pkg::RATE_W-1:0] rate, input int n,
                       input bit restart_first, input bit no_idle);
    write_rate(rate);
    quiet = no_idle;
    stream(n, restart_first);
    wait_idle();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Boundaries at the reset rate of 60: period 16666, overrun above 25000.
    push_req(OP_NEXT,    32'd0,          20'd0);
    push_req(OP_NEXT,    32'd0,          20'd0);
    push_req(OP_RESTART, 32'hFFFFFFFF,   20'd999999);
    push_req(OP_NEXT,    32'hFFFFFFFF,   20'd999999);
    push_req(OP_NEXT,    32'd0,          20'd10000);
    push_req(OP_RESTART, 32'd5,          20'hFFFFF);
    push_req(OP_NEXT,    32'd5,          20'hFFFFF);
    push_req(OP_NEXT,    32'h80000005,   20'd0);
    push_req(OP_RESTART, 32'h92345678,   20'h5A5A5);
    push_req(OP_NEXT,    32'h12345679,   20'h5A5A5);
    push_req(OP_RESTART, 32'h92345678,   20'h5A5A5);
    push_req(OP_NEXT,    32'h12345678,   20'h5A5A5);
    // Exactly on the deadline, exactly at the overrun limit, one past it,
    // then one microsecond late.
    push_req(OP_RESTART, 32'd100,        20'd0);
    push_req(OP_NEXT,    32'd100,        20'd16666);
    push_req(OP_NEXT,    32'd100,        20'd8333);
    push_req(OP_NEXT,    32'd100,        20'd24999);
    push_req(OP_NEXT,    32'd100,        20'd58332);
    // A deadline several seconds ahead with a smaller microsecond part.
    push_req(OP_RESTART, 32'd200,        20'd0);
    push_req(OP_NEXT,    32'd196,        20'd900000);
    // A rate of zero acts as one frame per second.
    write_rate(10'd0);
    push_req(OP_RESTART, 32'd0,          20'd0);
    push_req(OP_NEXT,    32'd0,          20'd0);
    push_req(OP_NEXT,    32'd1,          20'd500000);
    write_rate(10'd1023);
    push_req(OP_RESTART, 32'd7,          20'd999999);
    push_req(OP_NEXT,    32'd7,          20'd999999);
    push_req(OP_NEXT,    32'd8,          20'd0);

    t_us = longint'($urandom) * 1000000 + $urandom_range(999999);
    phase(10'd60,   200, 1'b1, 1'b0);
    phase(10'd1000, 300, 1'b1, 1'b0);
    // No restart after a lower rate: the frame count folds back on its own.
    phase(10'd7,    120, 1'b0, 1'b0);
    phase(10'd1,    100, 1'b1, 1'b0);
    phase(10'd1023, 150, 1'b1, 1'b1);
    phase(10'd0,     60, 1'b1, 1'b0);
    phase(10'd30,   150, 1'b0, 1'b0);
    t_us = longint'(32'hFFFFFFFE) * 1000000 + $urandom_range(999999);
    phase(10'd144,  200, 1'b1, 1'b0);
    phase(10'($urandom_range(2, 999)), 150, 1'b1, 1'b0);
    phase(10'd12,   120, 1'b0, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
